// ===== rtl/core/bpc_pkg.sv =====
// Shared types, constants and fixed-point helpers of the position controller.
package bpc_pkg;

   // Table size exponent of the cosine lookup
   localparam int unsigned COS_TABLE_BITS_DEF = 10;

   // Phase and cosine constants
   localparam logic [32:0] INV_TWO_PI_Q32 = 33'd683565276;
   localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
   // ceil(2^33 / 15): exact quotient for dividends below 2^29
   localparam logic [32:0] DIV15_RECIP    = 33'd572662307;

   // Configuration register indexes
   localparam logic [2:0] CSR_DRIVE_GAIN    = 3'd0;
   localparam logic [2:0] CSR_POSITION_GAIN = 3'd1;
   localparam logic [2:0] CSR_VELOCITY_GAIN = 3'd2;
   localparam logic [2:0] CSR_ERROR_BAND    = 3'd3;
   localparam logic [2:0] CSR_RESTART_MODE  = 3'd4;
   localparam logic [2:0] CSR_COUNT_CAP     = 3'd5;
   localparam logic [2:0] CSR_TICK_PERIOD   = 3'd6;
   localparam logic [2:0] CSR_TICK_RATE     = 3'd7;

   // Operand pair of the shared multiplier
   typedef struct packed {
      logic signed [32:0] a;
      logic signed [32:0] b;
   } mul_req_type;

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Q16.16 product: divide by 2^16 toward zero, then saturate
   function automatic logic signed [31:0] fmt_q16(input logic signed [65:0] p);
      logic signed [65:0] adj;
      adj = p + (p[65] ? 66'sd65535 : 66'sd0);
      return sat32(adj >>> 16);
   endfunction

   // Current: divide by 2^32 toward zero, then saturate to 16 bits
   function automatic logic signed [15:0] fmt_cur(input logic signed [65:0] p);
      logic signed [65:0] adj;
      logic signed [65:0] s;
      adj = p + (p[65] ? 66'sd4294967295 : 66'sd0);
      s = adj >>> 32;
      if (s > 66'sd32767) begin
         return 16'sh7FFF;
      end else if (s < -66'sd32768) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

   // Taylor cosine on [0, pi/2] in Q30, evaluated at elaboration only
   function automatic logic signed [63:0] cos_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      return sum;
   endfunction

endpackage

// ===== rtl/core/bpc_cos_rom.sv =====
// Cosine lookup ROM over one full turn, signed Q2.16 (18 bits), registered read.
module bpc_cos_rom
   import bpc_pkg::*;
#(
   parameter int unsigned COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic [COS_TABLE_BITS-1:0]     rd_index,
   output logic signed [17:0]            rd_data
);

   localparam int unsigned DEPTH   = 1 << COS_TABLE_BITS;
   localparam int unsigned QSHIFT  = COS_TABLE_BITS - 2;

   typedef logic signed [17:0] rom_type [DEPTH];

   // Build the table from quarter-wave symmetry
   function automatic rom_type build_rom();
      rom_type t;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] y;
      logic signed [63:0] v;
      for (int unsigned i = 0; i < DEPTH; i++) begin
         r = 64'(i) & ((64'd1 << QSHIFT) - 64'd1);
         x = (r * HALF_PI_Q30) >> QSHIFT;
         y = HALF_PI_Q30 - x;
         case (i >> QSHIFT)
            0:       v = cos_q30(x);
            1:       v = -cos_q30(y);
            2:       v = -cos_q30(x);
            default: v = cos_q30(y);
         endcase
         if (v >= 0) begin
            v = (v + 64'sd8192) >>> 14;
         end else begin
            v = -((-v + 64'sd8192) >>> 14);
         end
         t[i] = v[17:0];
      end
      return t;
   endfunction

   localparam rom_type COS_ROM = build_rom();

   logic signed [17:0] rd_ff;

   // Read one entry a cycle
   always_ff @(posedge clock) begin
      rd_ff <= COS_ROM[rd_index];
   end

   assign rd_data = rd_ff;

endmodule

// ===== rtl/core/bpc_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
module bpc_mul
   import bpc_pkg::*;
(
   input  logic                clock,
   input  mul_req_type         req,
   output logic signed [65:0]  prod
);

   logic signed [65:0] prod_ff;
   logic signed [65:0] prod_in;

   // Form the full product of the issued operands
   assign prod_in = 66'(req.a) * 66'(req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/backstepping_position_controller.sv =====
// Top level: backstepping position controller with a shared multiplier sequencer.
//
// Usage: one request item per control tick on req_*: target angle, motor speed
// in rpm and measured angle. Each request yields exactly one response item on
// rsp_* carrying the saturated 16-bit current command.
// Gains, band, counter mode and cap, and the tick period and rate are written
// on the csr_* port while the block is idle; they take effect for the next item.
// The work runs as 14 multiply steps on one 33x33 multiplier, each step an
// issue state followed by a write-back state. req_tready is low while an item
// is being worked on, so a new item is taken only once the last one is done.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver still stalls when the next result is done, the block
// holds that result in its last step and stays busy until rsp_tready.
// Reset (synchronous, active high) loads the default registers, clears the
// previous target and target rate, sets the step counter to one and drops
// rsp_tvalid.
module backstepping_position_controller
   import bpc_pkg::*;
#(
   parameter int unsigned COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] target_angle, [47:32] measured_speed, [79:48] measured_angle
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] current_command
   output logic [15:0]  rsp_tdata,
   input  logic         csr_wen,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WB    = 2'd2;

   // Multiply steps in order
   localparam logic [3:0] OP_PHASE  = 4'd0;
   localparam logic [3:0] OP_RATE   = 4'd1;
   localparam logic [3:0] OP_CSQ    = 4'd2;
   localparam logic [3:0] OP_ACCEL  = 4'd3;
   localparam logic [3:0] OP_OMEGA  = 4'd4;
   localparam logic [3:0] OP_K1E1   = 4'd5;
   localparam logic [3:0] OP_K1K1   = 4'd6;
   localparam logic [3:0] OP_INT1   = 4'd7;
   localparam logic [3:0] OP_INT2   = 4'd8;
   localparam logic [3:0] OP_INT3   = 4'd9;
   localparam logic [3:0] OP_K1E2   = 4'd10;
   localparam logic [3:0] OP_K1K1E1 = 4'd11;
   localparam logic [3:0] OP_K2E2   = 4'd12;
   localparam logic [3:0] OP_CUR    = 4'd13;

   // Configuration registers
   logic [30:0] drive_gain_ff, position_gain_ff, velocity_gain_ff, error_band_ff;
   logic [30:0] tick_period_ff, tick_rate_ff;
   logic        restart_mode_ff;
   logic [31:0] count_cap_ff;

   // Controller state
   logic signed [31:0] last_target_ff, last_rate_ff;
   logic [31:0]        step_ff, step_in;

   // Sequencer and working registers
   logic [1:0]         state_ff;
   logic [3:0]         op_ff;
   logic signed [31:0] target_ff, diff_ff, e1_ff, e2_ff, rate_ff, drate_ff;
   logic signed [31:0] tmp_ff, omega_ff, k1k1_ff, csq_ff;
   logic signed [15:0] speed_ff;
   logic signed [35:0] acc_ff;
   logic [COS_TABLE_BITS-1:0] idx_ff;
   logic               rsp_tvalid_ff;
   logic [15:0]        rsp_data_ff;

   mul_req_type        mreq;
   logic signed [65:0] prod;
   logic signed [17:0] cos_val;
   logic signed [31:0] prod_q16;
   logic signed [31:0] req_target, req_angle;
   logic [16:0]        speed_mag;
   logic [32:0]        phase_sum;
   logic [32:0]        e1_mag;
   logic signed [31:0] omega_q;
   logic               rsp_free;
   logic               rsp_done;

   bpc_mul u_mul (
      .clock (clock),
      .req   (mreq),
      .prod  (prod)
   );

   bpc_cos_rom #(
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_rom (
      .clock    (clock),
      .rd_index (idx_ff),
      .rd_data  (cos_val)
   );

   assign req_target = $signed(req_tdata[31:0]);
   assign req_angle  = $signed(req_tdata[79:48]);
   assign prod_q16   = fmt_q16(prod);
   assign speed_mag  = speed_ff[15] ? 17'(-18'(speed_ff)) : 17'(speed_ff);
   assign phase_sum  = {1'b0, prod[47:16]} + (33'd1 << (31 - COS_TABLE_BITS));
   assign omega_q    = speed_ff[15] ? -$signed(prod[64:33]) : $signed(prod[64:33]);
   assign e1_mag     = e1_ff[31] ? -33'(e1_ff) : 33'(e1_ff);
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_done   = (state_ff == ST_WB) && (op_ff == OP_CUR) && rsp_free;

   // Select multiplier operands for the current step
   always_comb begin
      mreq.a = 33'(target_ff);
      mreq.b = $signed(INV_TWO_PI_Q32);
      case (op_ff)
         OP_PHASE: begin
            mreq.a = 33'(target_ff);
            mreq.b = $signed(INV_TWO_PI_Q32);
         end
         OP_RATE: begin
            mreq.a = 33'(diff_ff);
            mreq.b = $signed({2'b0, tick_rate_ff});
         end
         OP_CSQ: begin
            mreq.a = 33'(cos_val);
            mreq.b = 33'(cos_val);
         end
         OP_ACCEL: begin
            mreq.a = 33'(drate_ff);
            mreq.b = $signed({2'b0, tick_rate_ff});
         end
         OP_OMEGA: begin
            mreq.a = $signed({2'b0, speed_mag, 14'd0});
            mreq.b = $signed(DIV15_RECIP);
         end
         OP_K1E1: begin
            mreq.a = $signed({2'b0, position_gain_ff});
            mreq.b = 33'(e1_ff);
         end
         OP_K1K1: begin
            mreq.a = $signed({2'b0, position_gain_ff});
            mreq.b = $signed({2'b0, position_gain_ff});
         end
         OP_INT1: begin
            mreq.a = 33'(e2_ff);
            mreq.b = 33'(csq_ff);
         end
         OP_INT2: begin
            mreq.a = 33'(tmp_ff);
            mreq.b = $signed({1'b0, step_ff});
         end
         OP_INT3: begin
            mreq.a = 33'(tmp_ff);
            mreq.b = $signed({2'b0, tick_period_ff});
         end
         OP_K1E2: begin
            mreq.a = $signed({2'b0, position_gain_ff});
            mreq.b = 33'(e2_ff);
         end
         OP_K1K1E1: begin
            mreq.a = 33'(k1k1_ff);
            mreq.b = 33'(e1_ff);
         end
         OP_K2E2: begin
            mreq.a = $signed({2'b0, velocity_gain_ff});
            mreq.b = 33'(e2_ff);
         end
         OP_CUR: begin
            mreq.a = 33'(sat32(66'(acc_ff)));
            mreq.b = $signed({2'b0, drive_gain_ff});
         end
         default: begin
            mreq.a = 33'(target_ff);
            mreq.b = $signed(INV_TWO_PI_Q32);
         end
      endcase
   end

   // Advance the step counter: in restart mode restart inside the band, else saturate at the cap
   always_comb begin
      logic [31:0] base;
      logic [31:0] inc;
      base = step_ff;
      if (restart_mode_ff && (e1_mag < {2'b0, error_band_ff})) begin
         base = 32'd1;
      end
      inc = (base == 32'hFFFFFFFF) ? base : base + 32'd1;
      step_in = inc;
      if (!restart_mode_ff && (inc > count_cap_ff)) begin
         step_in = count_cap_ff;
      end
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_gain_ff    <= 31'd65536;
         position_gain_ff <= 31'd65536;
         velocity_gain_ff <= 31'd65536;
         error_band_ff    <= 31'd1573;
         restart_mode_ff  <= 1'b1;
         count_cap_ff     <= 32'd1000;
         tick_period_ff   <= 31'd66;
         tick_rate_ff     <= 31'd65536000;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_DRIVE_GAIN:    drive_gain_ff    <= csr_wdata[30:0];
            CSR_POSITION_GAIN: position_gain_ff <= csr_wdata[30:0];
            CSR_VELOCITY_GAIN: velocity_gain_ff <= csr_wdata[30:0];
            CSR_ERROR_BAND:    error_band_ff    <= csr_wdata[30:0];
            CSR_RESTART_MODE:  restart_mode_ff  <= csr_wdata[0];
            CSR_COUNT_CAP:     count_cap_ff     <= csr_wdata;
            CSR_TICK_PERIOD:   tick_period_ff   <= csr_wdata[30:0];
            CSR_TICK_RATE:     tick_rate_ff     <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // Sequence the steps and hold controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         op_ff          <= OP_PHASE;
         last_target_ff <= '0;
         last_rate_ff   <= '0;
         step_ff        <= 32'd1;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !rsp_done) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  target_ff <= req_target;
                  speed_ff  <= $signed(req_tdata[47:32]);
                  diff_ff   <= sat32(66'(req_target) - 66'(last_target_ff));
                  e1_ff     <= sat32(66'(req_target) - 66'(req_angle));
                  acc_ff    <= 36'(sat32(66'(req_target) - 66'(req_angle)));
                  op_ff     <= OP_PHASE;
                  state_ff  <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               state_ff <= ST_WB;
            end
            ST_WB: begin
               if (op_ff != OP_CUR) begin
                  state_ff <= ST_ISSUE;
                  op_ff    <= op_ff + 4'd1;
               end
               case (op_ff)
                  OP_PHASE:  idx_ff   <= phase_sum[31 -: COS_TABLE_BITS];
                  OP_RATE: begin
                     rate_ff  <= prod_q16;
                     drate_ff <= sat32(66'(prod_q16) - 66'(last_rate_ff));
                  end
                  OP_CSQ:    csq_ff   <= prod[47:16];
                  OP_ACCEL:  acc_ff   <= acc_ff + 36'(prod_q16);
                  OP_OMEGA:  omega_ff <= omega_q;
                  OP_K1E1: begin
                     e2_ff <= sat32(66'(rate_ff) + 66'(prod_q16) - 66'(omega_ff));
                  end
                  OP_K1K1:   k1k1_ff  <= prod_q16;
                  OP_INT1:   tmp_ff   <= prod_q16;
                  OP_INT2:   tmp_ff   <= sat32(prod);
                  OP_INT3:   acc_ff   <= acc_ff + 36'(prod_q16);
                  OP_K1E2:   acc_ff   <= acc_ff + 36'(prod_q16);
                  OP_K1K1E1: acc_ff   <= acc_ff - 36'(prod_q16);
                  OP_K2E2:   acc_ff   <= acc_ff + 36'(prod_q16);
                  OP_CUR: begin
                     // Hold the finished result until the output register frees up
                     if (rsp_free) begin
                        rsp_data_ff    <= fmt_cur(prod);
                        rsp_tvalid_ff  <= 1'b1;
                        step_ff        <= step_in;
                        last_target_ff <= target_ff;
                        last_rate_ff   <= rate_ff;
                        state_ff       <= ST_IDLE;
                     end
                  end
                  default: ;
               endcase
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A new result appears only when the final step retires
   a_rsp_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_WB && op_ff == OP_CUR))
      else $error("response raised outside the final step");

   // Every issue cycle is followed by its write-back
   a_issue_then_wb: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |=> state_ff == ST_WB)
      else $error("issue not followed by write-back");

   // The step index never runs past the final step
   a_op_in_range: assert property (@(posedge clock) disable iff (reset)
      op_ff <= OP_CUR)
      else $error("step index out of range");

   // An accepted item starts at the first step
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_ISSUE && op_ff == OP_PHASE)
      else $error("accepted item did not start the sequence");

endmodule
